/* src/ialu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package ialu_pkg;
    localparam int DataWidthDefault = 32;
    localparam int ReqTypeWidth = 4;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3, OP_REM = 4'd4,
        OP_POW = 4'd5, OP_AND = 4'd6, OP_OR = 4'd7, OP_XOR = 4'd8, OP_NOT = 4'd9
    } t_op;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture operands and opcode
        logic step;       // one iteration of div / pow
        logic pow_mul;    // pow: phase 1 of an iteration (acc * sq)
        logic finish;     // form result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic iterative;  // opcode needs the shared loop
        logic last;       // final iteration reached
    } t_status;
endpackage
`default_nettype wire

/* src/integer_alu_with_modpow.sv */
`timescale 1ns / 1ps
`default_nettype none
// Unsigned integer ALU: add, sub, mul, div, rem, pow mod 2^(W-1), and, or, xor, not.
// Usage: drive i_req_type, i_operand_a, i_operand_b and raise start while busy is
// low; the request transfers on that edge and busy rises.
// The result appears on o_result / o_status, marked by o_valid for exactly
// one cycle. The receiver cannot stall; it must take the result in that cycle.
// States from transfer to o_valid (o_valid is registered from done):
//   add, sub, mul, logic ops: decode, then done.
//   div, rem, pow: decode, then per operand bit a multiply phase and a
//   step of the shared multiplier / subtractor, then done. For pow one
//   phase forms acc*sq, the next squares; div uses restoring shift-subtract.
// One request at a time: busy is low during the o_valid cycle, so the next
// request can transfer at the edge that ends it.
// Divide or remainder by zero gives result 0 with status 1.
// Reset (synchronous, active low) returns the controller to idle and
// drops o_valid; no request in flight survives it.
module integer_alu_with_modpow #(
    parameter int DATA_WIDTH = ialu_pkg::DataWidthDefault
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [ialu_pkg::ReqTypeWidth-1:0] i_req_type,
    input  wire logic [DATA_WIDTH-1:0]             i_operand_a,
    input  wire logic [DATA_WIDTH-1:0]             i_operand_b,
    output logic                                   o_valid,
    output logic [DATA_WIDTH-1:0]                  o_result,
    output logic                                   o_status
);
    import ialu_pkg::*;

    t_cmd    cmd;
    t_status status;

    ialu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_status(status),
        .o_cmd   (cmd),
        .o_valid (o_valid)
    );

    ialu_dp #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
        .i_clk      (i_clk),
        .i_cmd      (cmd),
        .i_req_type (i_req_type),
        .i_operand_a(i_operand_a),
        .i_operand_b(i_operand_b),
        .o_status   (status),
        .o_result   (o_result),
        .o_err      (o_status)
    );
endmodule
`default_nettype wire

/* src/ialu_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module ialu_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire ialu_pkg::t_status i_status,
    output ialu_pkg::t_cmd         o_cmd,
    output logic                   o_valid
);
    import ialu_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DECODE = 5'b00010,
        S_MULA  = 5'b00100,
        S_STEP  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = i_status.iterative ? S_MULA : S_DONE;
            end
            S_MULA: begin
                o_cmd.pow_mul = 1'b1;
                n_state = S_STEP;
            end
            S_STEP: begin
                o_cmd.step = 1'b1;
                n_state = i_status.last ? S_DONE : S_MULA;
            end
            S_DONE: begin
                o_cmd.finish = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            o_valid <= o_cmd.finish;
        end
    end

    assign busy = (r_state != S_IDLE);
endmodule
`default_nettype wire

/* src/ialu_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
module ialu_dp #(
    parameter int DATA_WIDTH = ialu_pkg::DataWidthDefault
) (
    input  wire logic                             i_clk,
    input  wire ialu_pkg::t_cmd                   i_cmd,
    input  wire logic [ialu_pkg::ReqTypeWidth-1:0] i_req_type,
    input  wire logic [DATA_WIDTH-1:0]            i_operand_a,
    input  wire logic [DATA_WIDTH-1:0]            i_operand_b,
    output ialu_pkg::t_status                     o_status,
    output logic [DATA_WIDTH-1:0]                 o_result,
    output logic                                  o_err
);
    import ialu_pkg::*;

    localparam int CntW = $clog2(DATA_WIDTH);
    localparam int PW = DATA_WIDTH - 1;

    t_op                   r_op;
    logic [DATA_WIDTH-1:0] r_a, r_b;
    logic [DATA_WIDTH-1:0] r_q;        // quotient / exponent shifter
    logic [DATA_WIDTH-1:0] r_rem;      // partial remainder / pow accumulator
    logic [DATA_WIDTH-1:0] r_sq;       // pow square
    logic [CntW-1:0]       r_cnt;
    logic [DATA_WIDTH-1:0] r_mul;      // product register

    // one shared multiplier; operand choice depends on opcode and pow phase
    logic [DATA_WIDTH-1:0] mul_x, mul_y;
    logic [2*DATA_WIDTH-1:0] mul_full;
    logic [DATA_WIDTH:0]   trial;
    logic [DATA_WIDTH:0]   shifted;
    logic [DATA_WIDTH-1:0] logic_res;
    logic                  is_div;

    assign is_div = (r_op == OP_DIV) || (r_op == OP_REM);

    always_comb begin
        if (r_op == OP_POW) begin
            mul_x = i_cmd.pow_mul ? r_rem : r_sq;
            mul_y = i_cmd.pow_mul ? r_sq  : r_sq;
        end else begin
            mul_x = r_a;
            mul_y = r_b;
        end
    end
    assign mul_full = mul_x * mul_y;

    assign shifted = {r_rem, r_q[DATA_WIDTH-1]};
    assign trial   = shifted - {1'b0, r_b};

    always_comb begin
        unique case (r_op)
            OP_ADD:  logic_res = r_a + r_b;
            OP_SUB:  logic_res = r_a - r_b;
            OP_MUL:  logic_res = r_mul;
            OP_AND:  logic_res = r_a & r_b;
            OP_OR:   logic_res = r_a | r_b;
            OP_XOR:  logic_res = r_a ^ r_b;
            OP_NOT:  logic_res = ~r_a;
            default: logic_res = '0;
        endcase
    end

    assign o_status.iterative = is_div || (r_op == OP_POW);
    assign o_status.last = (r_cnt == CntW'(DATA_WIDTH - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= t_op'(i_req_type);
            r_a   <= i_operand_a;
            r_b   <= i_operand_b;
            r_cnt <= '0;
        end else begin
            // product register used for mul and pow
            r_mul <= mul_full[DATA_WIDTH-1:0];
            if (!i_cmd.step && !i_cmd.pow_mul && !i_cmd.finish) begin
                // idle and decode cycles: seed the loop
                if (r_op == OP_POW) begin
                    r_rem <= DATA_WIDTH'(1);
                    r_sq  <= {1'b0, r_a[PW-1:0]};
                    r_q   <= r_b;
                end else begin
                    r_rem <= '0;
                    r_q   <= r_a;
                end
            end
            if (i_cmd.step) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_op == OP_POW) begin
                    if (r_q[0]) r_rem <= {1'b0, r_mul[PW-1:0]};
                    r_sq <= {1'b0, mul_full[PW-1:0]};
                    r_q  <= r_q >> 1;
                end else begin
                    if (!trial[DATA_WIDTH]) r_rem <= trial[DATA_WIDTH-1:0];
                    else r_rem <= shifted[DATA_WIDTH-1:0];
                    r_q <= {r_q[DATA_WIDTH-2:0], ~trial[DATA_WIDTH]};
                end
            end
            if (i_cmd.finish) begin
                o_err <= 1'b0;
                if (is_div) begin
                    if (r_b == '0) begin
                        o_result <= '0;
                        o_err <= 1'b1;
                    end else begin
                        o_result <= (r_op == OP_DIV) ? r_q : r_rem;
                    end
                end else if (r_op == OP_POW) begin
                    o_result <= r_rem;
                end else begin
                    o_result <= logic_res;
                end
            end
        end
    end
endmodule
`default_nettype wire
